// File: rtl/voxel_selection_bit_volume_assert.svh
// ----------------------------------------------------------------------------
// Voxel selection bit volume assertion macros
// Shared concurrent assertion forms, clocked on clk; the first two are disabled by rst.
// ----------------------------------------------------------------------------
`ifndef VOXEL_SELECTION_BIT_VOLUME_ASSERT_SVH
`define VOXEL_SELECTION_BIT_VOLUME_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define VSBV_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("vsbv assertion failed");

// Next-cycle implication, checked outside reset
`define VSBV_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("vsbv assertion failed");

// Next-cycle implication, checked through reset as well
`define VSBV_ASSERT_NEXT_ALWAYS(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("vsbv assertion failed");

`endif

// File: rtl/vsbv_pkg.sv
// ----------------------------------------------------------------------------
// vsbv_pkg
// Types, constants and codes shared by the voxel selection bit volume.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package vsbv_pkg;

  // Store geometry (both are powers of two)
  localparam int MAX_VOXELS  = 262144;
  localparam int WORD_BITS   = 64;
  localparam int PLANE_WORDS = (MAX_VOXELS + WORD_BITS - 1) / WORD_BITS;
  localparam int WORD_AW     = $clog2(PLANE_WORDS);
  localparam int BIT_W       = $clog2(WORD_BITS);

  // Field widths
  localparam int FUNC_W  = 2;
  localparam int COORD_W = 6;
  localparam int SIZE_W  = 7;
  localparam int MODE_W  = 2;
  localparam int CIDX_W  = 2;

  // Address arithmetic widths: size*y, size*size, size*size*z, x+size*y, full sum
  localparam int XY_W   = SIZE_W + COORD_W;
  localparam int SXY_W  = 2 * SIZE_W;
  localparam int Z_W    = SXY_W + COORD_W;
  localparam int PART_W = XY_W + 1;
  localparam int ADDR_W = 25;

  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(64);

  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [WORD_AW-1:0]   widx_t;
  typedef logic [BIT_W-1:0]     bidx_t;

  typedef enum logic [FUNC_W-1:0] {
    FN_MARK  = 2'd0,
    FN_READ  = 2'd1,
    FN_SNAP  = 2'd2,
    FN_CLEAR = 2'd3
  } func_e;

  typedef enum logic [MODE_W-1:0] {
    MODE_UNION     = 2'd0,
    MODE_INTERSECT = 2'd1,
    MODE_EXCLUDE   = 2'd2,
    MODE_HOLD      = 2'd3
  } mode_e;

  typedef enum logic [CIDX_W-1:0] {
    CFG_SIZE_X = 2'd0,
    CFG_SIZE_Y = 2'd1,
    CFG_SIZE_Z = 2'd2,
    CFG_MODE   = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic [COORD_W-1:0] coord_x;
    logic [COORD_W-1:0] coord_y;
    logic [COORD_W-1:0] coord_z;
    logic               clear_after;
  } item_t;

  // Controller to datapath
  typedef struct packed {
    logic load_item;
    logic mul1;
    logic mul2;
    logic look;
    logic commit;
    logic sweep_step;
    logic zero_all;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic sweep_item;
    logic sweep_last;
    logic out_free;
  } stat_t;

endpackage

// File: rtl/vsbv_if.sv
// ----------------------------------------------------------------------------
// vsbv_if
// Valid/ready channels of the voxel selection bit volume.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface vsbv_item_if;
  import vsbv_pkg::*;
  logic               valid;
  logic               ready;
  logic [FUNC_W-1:0]  func;
  logic [COORD_W-1:0] coord_x;
  logic [COORD_W-1:0] coord_y;
  logic [COORD_W-1:0] coord_z;
  logic               clear_after;
  modport source (output valid, func, coord_x, coord_y, coord_z, clear_after, input ready);
  modport sink   (input valid, func, coord_x, coord_y, coord_z, clear_after, output ready);
endinterface

interface vsbv_result_if;
  logic valid;
  logic ready;
  logic fill_bit;
  logic save_bit;
  logic in_range;
  modport source (output valid, fill_bit, save_bit, in_range, input ready);
  modport sink   (input valid, fill_bit, save_bit, in_range, output ready);
endinterface

interface vsbv_cfg_if;
  import vsbv_pkg::*;
  logic              valid;
  logic              ready;
  logic [CIDX_W-1:0] index;
  logic [SIZE_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/vsbv_ctrl.sv
// ----------------------------------------------------------------------------
// vsbv_ctrl
// Sequencer: reset clearing pass, address stages, plane sweeps, lookup.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vsbv_ctrl
  import vsbv_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  item_valid,
  output logic  item_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  typedef enum logic [2:0] {
    ST_INIT,
    ST_INIT_DRAIN,
    ST_IDLE,
    ST_MUL1,
    ST_MUL2,
    ST_SWEEP,
    ST_DRAIN,
    ST_LOOK
  } state_t;

  state_t state;
  state_t state_next;
  logic   in_commit;
  logic   commit_q;

  // Decode commands and next state
  always_comb begin
    cmd        = '0;
    cmd.commit = commit_q;
    item_ready = 1'b0;
    state_next = state;
    in_commit  = 1'b0;
    unique case (state)
      ST_INIT: begin
        cmd.sweep_step = 1'b1;
        cmd.zero_all   = 1'b1;
        if (stat.sweep_last) state_next = ST_INIT_DRAIN;
      end
      ST_INIT_DRAIN: state_next = ST_IDLE;
      ST_IDLE: begin
        item_ready    = 1'b1;
        cmd.load_item = item_valid;
        if (item_valid) state_next = ST_MUL1;
      end
      ST_MUL1: begin
        cmd.mul1   = 1'b1;
        state_next = ST_MUL2;
      end
      ST_MUL2: begin
        cmd.mul2   = 1'b1;
        state_next = stat.sweep_item ? ST_SWEEP : ST_LOOK;
      end
      ST_SWEEP: begin
        cmd.sweep_step = 1'b1;
        if (stat.sweep_last) state_next = ST_DRAIN;
      end
      ST_DRAIN: state_next = ST_LOOK;
      ST_LOOK: begin
        // read both planes; move on once the result register will be free
        cmd.look = 1'b1;
        if (stat.out_free) state_next = ST_IDLE;
        in_commit = stat.out_free;
      end
      default: state_next = ST_INIT;
    endcase
  end

  // Hold state and the registered commit strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_INIT;
      commit_q <= 1'b0;
    end else begin
      state    <= state_next;
      commit_q <= in_commit;
    end
  end

endmodule

// File: rtl/vsbv_datapath.sv
// ----------------------------------------------------------------------------
// vsbv_datapath
// Config registers, voxel address pipeline, the two planes and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vsbv_datapath
  import vsbv_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  input  logic [CIDX_W-1:0] cfg_index,
  input  logic [SIZE_W-1:0] cfg_data,
  input  item_t             item,
  input  cmd_t              cmd,
  output stat_t             stat,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_fill,
  output logic              out_save,
  output logic              out_range
);

  logic [SIZE_W-1:0] size_x, size_y, size_z;
  mode_e             mode;
  item_t             req;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      size_x <= SIZE_RESET;
      size_y <= SIZE_RESET;
      size_z <= SIZE_RESET;
      mode   <= MODE_UNION;
    end else if (cfg_valid) begin
      unique case (cfg_idx_e'(cfg_index))
        CFG_SIZE_X: size_x <= cfg_data;
        CFG_SIZE_Y: size_y <= cfg_data;
        CFG_SIZE_Z: size_z <= cfg_data;
        CFG_MODE:   mode   <= mode_e'(cfg_data[MODE_W-1:0]);
        default:    ;
      endcase
    end
  end

  // Latch the request
  always_ff @(posedge clk) begin
    if (cmd.load_item) req <= item;
  end

  // Address stages: products, then the final sum and bound tests
  logic [XY_W-1:0]   prod_xy;
  logic [SXY_W-1:0]  prod_sxy;
  logic [Z_W-1:0]    prod_z;
  logic [PART_W-1:0] part;

  always_ff @(posedge clk) begin
    if (cmd.mul1) begin
      prod_xy  <= XY_W'(size_x) * XY_W'(req.coord_y);
      prod_sxy <= SXY_W'(size_x) * SXY_W'(size_y);
    end
    if (cmd.mul2) begin
      prod_z <= Z_W'(prod_sxy) * Z_W'(req.coord_z);
      part   <= PART_W'(req.coord_x) + PART_W'(prod_xy);
    end
  end

  logic [ADDR_W-1:0] addr;
  logic              addr_ok;
  assign addr    = ADDR_W'(part) + ADDR_W'(prod_z);
  assign addr_ok = ({1'b0, req.coord_x} < size_x) && ({1'b0, req.coord_y} < size_y) &&
                   ({1'b0, req.coord_z} < size_z) && (addr < ADDR_W'(MAX_VOXELS));

  widx_t look_word;
  bidx_t look_bit;
  logic  look_ok;
  always_ff @(posedge clk) begin
    if (cmd.look) begin
      look_word <= addr[BIT_W +: WORD_AW];
      look_bit  <= addr[BIT_W-1:0];
      look_ok   <= addr_ok;
    end
  end

  // Sweep counter and the delayed write stage
  widx_t sweep_cnt;
  widx_t wp_addr;
  logic  wp_valid;
  logic  wp_zero;
  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_cnt <= '0;
      wp_valid  <= 1'b0;
    end else begin
      wp_valid <= cmd.sweep_step;
      if (cmd.sweep_step) sweep_cnt <= sweep_cnt + widx_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sweep_step) begin
      wp_addr <= sweep_cnt;
      wp_zero <= cmd.zero_all || (func_e'(req.func) == FN_CLEAR);
    end
  end

  // Planes
  word_t work_mem [PLANE_WORDS];
  word_t save_mem [PLANE_WORDS];
  word_t work_q, save_q;
  word_t mark_w, new_w, mask;
  logic  work_re, work_we, save_we;
  widx_t work_ra, work_wa;
  word_t work_wd, save_wd;
  logic  do_mark;

  assign mask    = word_t'(1) << look_bit;
  assign do_mark = look_ok && (func_e'(req.func) == FN_MARK);

  // Apply the marking rule to the looked-up word
  always_comb begin
    case (mode)
      MODE_UNION:     mark_w = work_q | mask;
      MODE_INTERSECT: mark_w = (work_q & ~mask) | (save_q & mask);
      MODE_EXCLUDE:   mark_w = work_q & ~mask;
      default:        mark_w = work_q;
    endcase
    new_w = do_mark ? mark_w : work_q;
  end

  // Select plane ports between sweep and lookup
  always_comb begin
    work_re = cmd.sweep_step || cmd.look;
    work_ra = cmd.sweep_step ? sweep_cnt : addr[BIT_W +: WORD_AW];
    work_we = (wp_valid && (wp_zero || req.clear_after)) || (cmd.commit && do_mark);
    work_wa = wp_valid ? wp_addr : look_word;
    work_wd = wp_valid ? '0 : mark_w;
    save_we = wp_valid;
    save_wd = wp_zero ? '0 : work_q;
  end

  always_ff @(posedge clk) begin
    if (work_re) work_q <= work_mem[work_ra];
    if (work_we) work_mem[work_wa] <= work_wd;
  end

  always_ff @(posedge clk) begin
    if (cmd.look) save_q <= save_mem[addr[BIT_W +: WORD_AW]];
    if (save_we) save_mem[wp_addr] <= save_wd;
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_fill  <= look_ok & new_w[look_bit];
      out_save  <= look_ok & save_q[look_bit];
      out_range <= look_ok;
    end
  end

  // Status
  assign stat.sweep_item = (func_e'(req.func) == FN_SNAP) || (func_e'(req.func) == FN_CLEAR);
  assign stat.sweep_last = (sweep_cnt == widx_t'(PLANE_WORDS - 1));
  assign stat.out_free   = !out_valid || out_ready;

endmodule

// File: rtl/voxel_selection_bit_volume.sv
// ----------------------------------------------------------------------------
// voxel_selection_bit_volume
// Working and saved voxel selection planes with mark, read and snapshot.
// ----------------------------------------------------------------------------
// Usage:
//   items   : one request per voxel operation (mark, read, snapshot, clear).
//   results : one response per request, in order: fill_bit, save_bit, in_range.
//   cfg     : register writes (size_x, size_y, size_z, select_mode), always
//             ready; write only while no request is in flight.
// Sequencing:
//   Mark and read: the request passes the two address multiplies and the
//   registered plane read; the next request can be taken at the edge that
//   makes its response valid, not before.
//   Snapshot and clear: a sweep that walks the planes one word a cycle runs
//   before the plane read.
// Reset: a clearing pass zeroes both planes; items.ready stays low until it
//   ends, cfg writes are taken meanwhile.
// Stall: the response waits in an output register; the next request is taken
//   and runs up to its plane read, then holds until the register frees.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module voxel_selection_bit_volume
  import vsbv_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  vsbv_item_if.sink     items,
  vsbv_result_if.source results,
  vsbv_cfg_if.sink      cfg
);

  cmd_t  cmd;
  stat_t stat;
  item_t item;

  assign cfg.ready        = 1'b1;
  assign item.func        = items.func;
  assign item.coord_x     = items.coord_x;
  assign item.coord_y     = items.coord_y;
  assign item.coord_z     = items.coord_z;
  assign item.clear_after = items.clear_after;

  vsbv_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (items.valid),
    .item_ready (items.ready),
    .stat       (stat),
    .cmd        (cmd)
  );

  vsbv_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg.valid),
    .cfg_index (cfg.index),
    .cfg_data  (cfg.data),
    .item      (item),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .out_fill  (results.fill_bit),
    .out_save  (results.save_bit),
    .out_range (results.in_range)
  );

endmodule

// File: rtl/vsbv_checker.sv
// ----------------------------------------------------------------------------
// vsbv_checker
// Port-level checks of the voxel selection bit volume, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "voxel_selection_bit_volume_assert.svh"

module vsbv_checker (
  input logic clk,
  input logic rst,
  input logic item_valid,
  input logic item_ready,
  input logic res_valid,
  input logic res_ready,
  input logic res_fill,
  input logic res_save,
  input logic res_range
);

  // Hold a stalled response
  `VSBV_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid)

  // Drop ready after a request: one request is worked at a time
  `VSBV_ASSERT_NEXT(a_one_at_a_time, item_valid && item_ready, !item_ready)

  // Out-of-range voxels read as zero in both planes
  `VSBV_ASSERT_IMPL(a_range_zero, res_valid && !res_range, !res_fill && !res_save)

  // Reset empties the response register and blocks requests
  `VSBV_ASSERT_NEXT_ALWAYS(a_reset_clear, rst, !res_valid && !item_ready)

endmodule

bind voxel_selection_bit_volume vsbv_checker u_vsbv_checker (
  .clk        (clk),
  .rst        (rst),
  .item_valid (items.valid),
  .item_ready (items.ready),
  .res_valid  (results.valid),
  .res_ready  (results.ready),
  .res_fill   (results.fill_bit),
  .res_save   (results.save_bit),
  .res_range  (results.in_range)
);
